// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the serial frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define IFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ifp assertion failed");

// Clocked assertion that is also checked during reset.
`define IFP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ifp assertion failed");

`endif

// ===== src/ifp_pkg.sv =====
// Types, codes and constants of the serial frame parser.
`default_nettype none

package ifp_pkg;

    // Parser phase: header positions, then version, type, length, payload, checksum.
    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_HDR2    = 4'd2,
        PH_HDR3    = 4'd3,
        PH_HDR4    = 4'd4,
        PH_HDR5    = 4'd5,
        PH_VERSION = 4'd6,
        PH_TYPE    = 4'd7,
        PH_LENGTH  = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_CHECK   = 4'd10
    } t_phase;

    // Frame status reported with the checksum word.
    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_SET_WIFI  = 3'd1,
        ST_DEV_INFO  = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_OTHER     = 3'd5,
        ST_BAD_CHECK = 3'd6
    } t_status;

    localparam logic [7:0] TYPE_RPC        = 8'h03;
    localparam logic [7:0] CMD_SET_WIFI    = 8'h01;
    localparam logic [7:0] CMD_DEVICE_INFO = 8'h02;
    localparam logic [7:0] CHAR_I          = 8'h49;

    // Parser state carried from word to word.
    typedef struct packed {
        t_phase     phase;
        logic [7:0] run_xor;
        logic [7:0] length;
        logic [7:0] count;
        logic [7:0] kind;
        logic [7:0] command;
    } t_state;

    // One result word.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        t_status    frame_status;
        logic [7:0] frame_kind;
        logic [7:0] rpc_command;
        logic [7:0] frame_length;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:   PH_HDR0,
        run_xor: 8'h00,
        length:  8'h00,
        count:   8'h00,
        kind:    8'h00,
        command: 8'h00
    };

    // Expected header character at a given match position ("IMPROV").
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                3'd0:    c = 8'h49;
                3'd1:    c = 8'h4D;
                3'd2:    c = 8'h50;
                3'd3:    c = 8'h52;
                3'd4:    c = 8'h4F;
                3'd5:    c = 8'h56;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/ifp_step.sv =====
// Next-state and result logic for one received word of the frame parser.
`default_nettype none

module ifp_step
    import ifp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_result    o_result
);

    logic [7:0] w_xor;
    logic [7:0] w_count_inc;

    assign w_xor       = i_state.run_xor ^ i_byte;
    assign w_count_inc = i_state.count + 8'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_state.phase)
            // Header hunt; a mismatch restarts, at position one on an 'I'.
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5: begin
                if (i_byte == hdr_char(i_state.phase[2:0])) begin
                    o_state.run_xor = w_xor;
                    o_state.phase   = t_phase'(i_state.phase + 4'd1);
                end else if (i_byte == CHAR_I) begin
                    o_state.run_xor = i_byte;
                    o_state.phase   = PH_HDR1;
                end else begin
                    o_state.run_xor = 8'h00;
                    o_state.phase   = PH_HDR0;
                end
            end
            PH_VERSION: begin
                o_state.run_xor = w_xor;
                o_state.phase   = PH_TYPE;
            end
            PH_TYPE: begin
                o_state.run_xor = w_xor;
                o_state.kind    = i_byte;
                o_state.phase   = PH_LENGTH;
            end
            PH_LENGTH: begin
                o_state.run_xor = w_xor;
                o_state.length  = i_byte;
                o_state.count   = 8'h00;
                o_state.command = 8'h00;
                o_state.phase   = (i_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
            end
            // Payload words leave at once, before the checksum is known.
            PH_PAYLOAD: begin
                o_state.run_xor        = w_xor;
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = i_state.count;
                if (i_state.count == 8'h00) begin
                    o_state.command = i_byte;
                end
                o_state.count = w_count_inc;
                if (w_count_inc == i_state.length) begin
                    o_state.phase = PH_CHECK;
                end
            end
            // Checksum word: classify the frame and restart the hunt.
            PH_CHECK: begin
                o_result.frame_done   = 1'b1;
                o_result.frame_kind   = i_state.kind;
                o_result.rpc_command  = i_state.command;
                o_result.frame_length = i_state.length;
                if (i_byte != i_state.run_xor) begin
                    o_result.frame_status = ST_BAD_CHECK;
                end else if (i_state.kind != TYPE_RPC) begin
                    o_result.frame_status = ST_OTHER;
                end else if (i_state.length == 8'h00) begin
                    o_result.frame_status = ST_EMPTY;
                end else if (i_state.command == CMD_SET_WIFI) begin
                    o_result.frame_status = ST_SET_WIFI;
                end else if (i_state.command == CMD_DEVICE_INFO) begin
                    o_result.frame_status = ST_DEV_INFO;
                end else begin
                    o_result.frame_status = ST_UNKNOWN;
                end
                o_state.run_xor = 8'h00;
                o_state.phase   = PH_HDR0;
            end
            // Unused phase codes act as header position zero.
            default: begin
                if (i_byte == CHAR_I) begin
                    o_state.run_xor = i_byte;
                    o_state.phase   = PH_HDR1;
                end else begin
                    o_state.run_xor = 8'h00;
                    o_state.phase   = PH_HDR0;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ifp_out_buf.sv =====
// Output register with a skid stage for the result words of the frame parser.
`default_nettype none

module ifp_out_buf
    import ifp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_free;

    // The output register can take a word when empty or being read this cycle.
    assign w_out_free = !r_out_valid || !i_stall;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || i_wr;
            r_skid_valid <= 1'b0;
        end else if (i_wr) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!w_out_free && i_wr) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== src/improv_serial_frame_parser.sv =====
// Top level of the serial frame parser: state registers, step logic, output buffer.
//
//  Channel | Direction | Handshake           | Word
//  --------+-----------+---------------------+----------------------------------------
//  input   | in        | i_valid / o_stall   | i_rx_byte
//  output  | out       | o_valid / i_stall   | payload, index, done, status, kind, ...
//
// Every received word gives exactly one result word, which is registered in the output buffer.
// The parser takes one word per cycle; the rate is set by the output register and
// its skid stage, which stalls the input only when both hold a word.
// Reset is synchronous and active low; it returns the parser to the start of the
// header hunt and empties the output stages.
`default_nettype none

module improv_serial_frame_parser
    import ifp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic       o_frame_done,
    output logic [2:0] o_frame_status,
    output logic [7:0] o_frame_kind,
    output logic [7:0] o_rpc_command,
    output logic [7:0] o_frame_length
);

    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    t_result w_out;
    logic    w_full;
    logic    w_accept;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    ifp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_rx_byte),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // Parser state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    ifp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_payload_valid = w_out.payload_valid;
    assign o_payload_byte  = w_out.payload_byte;
    assign o_payload_index = w_out.payload_index;
    assign o_frame_done    = w_out.frame_done;
    assign o_frame_status  = w_out.frame_status;
    assign o_frame_kind    = w_out.frame_kind;
    assign o_rpc_command   = w_out.rpc_command;
    assign o_frame_length  = w_out.frame_length;

endmodule

`default_nettype wire

// ===== src/ifp_checker.sv =====
// Port-level checker for the serial frame parser, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module ifp_checker
    import ifp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_payload_valid,
    input logic [7:0] o_payload_byte,
    input logic [7:0] o_payload_index,
    input logic       o_frame_done,
    input logic [2:0] o_frame_status,
    input logic [7:0] o_frame_kind,
    input logic [7:0] o_rpc_command,
    input logic [7:0] o_frame_length
);

    // A stalled result word stays valid and holds its payload byte, index and status.
    `IFP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_payload_byte) && $stable(o_frame_status) && $stable(o_payload_index))

    // A word is never both a payload word and a checksum word.
    `IFP_ASSERT(a_one_role, i_clk, i_rst_n, o_valid |-> !(o_payload_valid && o_frame_done))

    // Frame fields are zero unless the word ends a frame.
    `IFP_ASSERT(a_idle_fields, i_clk, i_rst_n, o_valid && !o_frame_done |-> o_frame_status == ST_NONE && o_frame_kind == 8'd0 && o_rpc_command == 8'd0 && o_frame_length == 8'd0)

    // A finished frame always carries a real status, and an empty payload no command.
    `IFP_ASSERT(a_done_status, i_clk, i_rst_n, o_valid && o_frame_done |-> o_frame_status != ST_NONE && o_frame_status <= ST_BAD_CHECK && (o_frame_length != 8'd0 || o_rpc_command == 8'd0))

    // The cycle after a reset edge shows no result and no stall.
    `IFP_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind improv_serial_frame_parser ifp_checker u_ifp_checker (.*);

`default_nettype wire
